@@ rtl/pcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared types, constants and helper functions for the PNG chunk writer.
// ----------------------------------------------------------------------------
package pcw_pkg;

  // Field widths.
  localparam int LEN_W  = 31;
  localparam int TYPE_W = 32;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 32;

  // Command queue depth between the front and back ends.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_COUNT = {LEN_W{1'b1}};
  localparam logic [CRC_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY  = 32'hEDB8_8320;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_SIG   = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_ORDER    = 2'd2
  } status_t;

  // One classified transaction handed from the front end to the back end.
  typedef struct packed {
    kind_t              kind;
    logic               order_err;
    logic               mismatch;
    logic [LEN_W-1:0]   len;
    logic [TYPE_W-1:0]  ctype;
    logic [BYTE_W-1:0]  dbyte;
  } cmd_t;

  // Fixed eight-byte PNG signature.
  function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  // Big-endian byte select from a 32-bit word; select 0 is the top byte.
  function automatic logic [BYTE_W-1:0] be_byte(input logic [31:0] word,
                                                 input logic [1:0] sel);
    logic [BYTE_W-1:0] b;
    case (sel)
      2'd0:    b = word[31:24];
      2'd1:    b = word[23:16];
      2'd2:    b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

  // One byte of the reflected CRC-32, eight bit steps.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/pcw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_front
// Accepts input transactions, checks chunk ordering, tracks the declared
// length and payload count, and pushes one command per item into the queue.
// ----------------------------------------------------------------------------
module pcw_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pcw_pkg::kind_t            kind,
  input  logic [pcw_pkg::LEN_W-1:0] body_length,
  input  logic [pcw_pkg::TYPE_W-1:0] chunk_type,
  input  logic [pcw_pkg::BYTE_W-1:0] data_byte,
  input  logic                      q_full,
  output logic                      push,
  output pcw_pkg::cmd_t             push_cmd
);
  import pcw_pkg::*;

  logic             chunk_open;
  logic [LEN_W-1:0] declared_length;
  logic [LEN_W-1:0] payload_count;
  logic             order_err;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // A signature or start needs a closed chunk; payload and end need an open one.
  always_comb begin
    case (kind)
      KIND_SIG, KIND_START: order_err = chunk_open;
      KIND_DATA, KIND_END:  order_err = !chunk_open;
      default:              order_err = 1'b1;
    endcase
  end

  // Build the command for the back end.
  always_comb begin
    push_cmd.kind      = kind;
    push_cmd.order_err = order_err;
    push_cmd.mismatch  = (payload_count != declared_length);
    push_cmd.len       = body_length;
    push_cmd.ctype     = chunk_type;
    push_cmd.dbyte     = data_byte;
  end

  // Chunk bookkeeping; an out-of-order item leaves it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_open      <= 1'b0;
      declared_length <= '0;
      payload_count   <= '0;
    end else if (push && !order_err) begin
      case (kind)
        KIND_START: begin
          chunk_open      <= 1'b1;
          declared_length <= body_length;
          payload_count   <= '0;
        end
        KIND_DATA: begin
          if (payload_count != MAX_COUNT) begin
            payload_count <= payload_count + 1'b1;
          end
        end
        KIND_END: begin
          chunk_open      <= 1'b0;
          declared_length <= '0;
          payload_count   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/pcw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_queue
// Small command FIFO that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
module pcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output pcw_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import pcw_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] level;

  assign full     = (level == QCNT_W'(QDEPTH));
  assign empty    = (level == '0);
  assign head_cmd = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

@@ rtl/pcw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_back
// Serializes queued commands into the byte stream, one byte per cycle while the
// consumer is ready, and runs the CRC-32 over type and payload bytes as sent.
// ----------------------------------------------------------------------------
module pcw_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  pcw_pkg::cmd_t              head_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pcw_pkg::BYTE_W-1:0] out_byte,
  output logic                       last_of_run,
  output logic [1:0]                 status
);
  import pcw_pkg::*;

  cmd_t              cur;
  logic              cur_valid;
  logic [2:0]        idx;
  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  crc_next;
  logic              out_load;
  logic              step;
  logic              is_last;
  logic [BYTE_W-1:0] byte_now;
  status_t           status_now;

  assign out_load = !out_valid || out_ready;
  assign step     = cur_valid && out_load;
  assign pop      = !q_empty && (!cur_valid || (step && is_last));

  // Byte, status and end of run for the current position.
  always_comb begin
    byte_now   = '0;
    status_now = STATUS_OK;
    is_last    = 1'b1;
    crc_next   = crc;
    if (cur.order_err) begin
      status_now = STATUS_ORDER;
    end else begin
      case (cur.kind)
        KIND_SIG: begin
          byte_now = sig_byte(idx);
          is_last  = (idx == 3'd7);
        end
        KIND_START: begin
          is_last = (idx == 3'd7);
          if (idx[2]) begin
            byte_now = be_byte(cur.ctype, idx[1:0]);
            crc_next = crc_byte((idx == 3'd4) ? CRC_INIT : crc, byte_now);
          end else begin
            byte_now = be_byte({1'b0, cur.len}, idx[1:0]);
          end
        end
        KIND_DATA: begin
          byte_now = cur.dbyte;
          crc_next = crc_byte(crc, cur.dbyte);
        end
        KIND_END: begin
          byte_now   = be_byte(~crc, idx[1:0]);
          is_last    = (idx == 3'd3);
          status_now = cur.mismatch ? STATUS_MISMATCH : STATUS_OK;
          crc_next   = (idx == 3'd3) ? CRC_INIT : crc;
        end
        default: begin
        end
      endcase
    end
  end

  // Current command and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      crc       <= CRC_INIT;
    end else begin
      if (step) begin
        crc <= crc_next;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (step) begin
        if (is_last) begin
          cur_valid <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
  end

  // Output register; holds while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte    <= byte_now;
      last_of_run <= is_last;
      status      <= status_now;
    end
  end

endmodule

@@ rtl/png_chunk_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_writer
// PNG chunk framing: signature, length/type header, payload and CRC-32.
// ----------------------------------------------------------------------------
// The block takes one input transaction per cycle while its four-entry command
// queue has room, and delivers one output byte per cycle when the consumer is
// ready. A signature or a start chunk produces 8 bytes, an end chunk 4 bytes,
// and a payload byte or an out-of-order item a single byte. The serializer
// sends one byte per cycle when the consumer is ready and updates its CRC-32
// a byte at a time, so payload bytes stream at one per cycle. The CRC covers
// the type and payload bytes only, and length mismatches are reported in the
// status of all four CRC bytes.
module png_chunk_writer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [pcw_pkg::LEN_W-1:0]  body_length,
  input  logic [pcw_pkg::TYPE_W-1:0] chunk_type,
  input  logic [pcw_pkg::BYTE_W-1:0] data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pcw_pkg::BYTE_W-1:0] out_byte,
  output logic                       last_of_run,
  output logic [1:0]                 status
);
  import pcw_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;

  // Front end: ordering checks and chunk bookkeeping.
  pcw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind_t'(kind)),
    .body_length (body_length),
    .chunk_type  (chunk_type),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Command queue between the two halves.
  pcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: byte serializer and CRC.
  pcw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .status      (status)
  );

`ifndef SYNTHESIS
  // An out-of-order result is a single zero byte that ends its run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ORDER) |-> (last_of_run && out_byte == 8'h00))
    else $error("out-of-order result is not a single zero byte");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // The serializer never pulls from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty command queue");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PNG chunk writer. A table of directed
// transactions covers the signature, header, payload and CRC paths, the
// out-of-order cases and length mismatches. A long random run of chunk
// sequences with noise follows. Every output byte is checked, against typed-in
// bytes or an in-bench model of the framing and CRC-32. Both handshakes idle
// in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import pcw_pkg::*;

  localparam int  RUN_LIMIT    = 200000;
  localparam int  RANDOM_ITEMS = 150;
  localparam int  TAIL_ITEMS   = 30;
  localparam int  DIR_ROWS     = 21;
  localparam int  TAIL_CYCLES  = 40;
  localparam int  MAX_PRINTS   = 100;

  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  // CRC-32 of the bare IEND chunk, as it appears in every PNG file.
  localparam logic [31:0] IEND_CRC  = 32'hAE42_6082;

  // One input transaction, with an optional typed-in expectation.
  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   len;
    logic [TYPE_W-1:0]  ctype;
    logic [BYTE_W-1:0]  dbyte;
    logic [3:0]         n_fixed;
    logic [63:0]        fixed_bytes;
    status_t            fixed_status;
  } stim_row_t;

  // One byte of the serialized stream.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    status_t           st;
  } stream_byte_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        kind;
  logic [LEN_W-1:0]  body_length;
  logic [TYPE_W-1:0] chunk_type;
  logic [BYTE_W-1:0] data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic [1:0]        status;

  stim_row_t    cur_item;
  stim_row_t    dir_table [DIR_ROWS];
  stream_byte_t awaited_bytes[$];
  stream_byte_t framed_bytes[$];

  // Model state of the framer.
  logic [CRC_W-1:0] crc_reg;
  logic             chunk_open;
  logic [LEN_W-1:0] declared_len;
  logic [LEN_W-1:0] byte_count;

  int  error_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  stall_left;
  bit  steady_tail = 1'b0;

  assign kind        = cur_item.kind;
  assign body_length = cur_item.len;
  assign chunk_type  = cur_item.ctype;
  assign data_byte   = cur_item.dbyte;

  png_chunk_writer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .body_length (body_length),
    .chunk_type  (chunk_type),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .status      (status)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Prints one mismatch line and counts it; printing stops after the first 100 errors.
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Bit-serial reflected CRC-32 over one byte, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] acc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[CRC_W-1:1]} ^ ((r[0] ^ b[k]) ? CRC_POLY : '0);
    end
    return r;
  endfunction

  function automatic void put_byte(input logic [7:0] d, input logic l, input status_t s);
    stream_byte_t sb;
    sb.data = d;
    sb.last = l;
    sb.st   = s;
    framed_bytes = {framed_bytes, sb};
  endfunction

  // Works out the bytes that one transaction produces and advances the state.
  function automatic void frame_item(input stim_row_t it);
    logic             order_fault;
    logic [31:0]      word;
    logic [CRC_W-1:0] c;
    status_t          st;
    framed_bytes.delete();
    order_fault = 1'b0;
    case (it.kind)
      KIND_SIG: begin
        if (chunk_open) order_fault = 1'b1;
        else begin
          for (int i = 0; i < 8; i++) put_byte(PNG_MAGIC[63-8*i -: 8], i == 7, STATUS_OK);
        end
      end
      KIND_START: begin
        if (chunk_open) order_fault = 1'b1;
        else begin
          word = {1'b0, it.len};
          for (int i = 0; i < 4; i++) put_byte(word[31-8*i -: 8], 1'b0, STATUS_OK);
          c = CRC_INIT;
          for (int i = 0; i < 4; i++) begin
            put_byte(it.ctype[31-8*i -: 8], i == 3, STATUS_OK);
            c = crc_fold(c, it.ctype[31-8*i -: 8]);
          end
          crc_reg      = c;
          chunk_open   = 1'b1;
          declared_len = it.len;
          byte_count   = '0;
        end
      end
      KIND_DATA: begin
        if (!chunk_open) order_fault = 1'b1;
        else begin
          put_byte(it.dbyte, 1'b1, STATUS_OK);
          crc_reg = crc_fold(crc_reg, it.dbyte);
          if (byte_count != MAX_COUNT) byte_count = byte_count + 1'b1;
        end
      end
      default: begin
        if (!chunk_open) order_fault = 1'b1;
        else begin
          word = ~crc_reg;
          st   = (byte_count != declared_len) ? STATUS_MISMATCH : STATUS_OK;
          for (int i = 0; i < 4; i++) put_byte(word[31-8*i -: 8], i == 3, st);
          crc_reg      = CRC_INIT;
          chunk_open   = 1'b0;
          declared_len = '0;
          byte_count   = '0;
        end
      end
    endcase
    if (order_fault) put_byte(8'h00, 1'b1, STATUS_ORDER);
  endfunction

  // Scoreboard: predicts on accepted input, compares on accepted output.
  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        frame_item(cur_item);
        if (cur_item.n_fixed != 0) begin
          for (int k = 0; k < cur_item.n_fixed; k++) begin
            want.data = cur_item.fixed_bytes[63-8*k -: 8];
            want.last = (k == cur_item.n_fixed - 1);
            want.st   = cur_item.fixed_status;
            awaited_bytes = {awaited_bytes, want};
          end
        end else begin
          awaited_bytes = {awaited_bytes, framed_bytes};
        end
      end
      if (out_valid && out_ready) begin
        if (awaited_bytes.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b status %0d",
                               out_byte, last_of_run, status));
        end else begin
          want = awaited_bytes.pop_front();
          if (out_byte !== want.data)
            flag_error($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          if (last_of_run !== want.last)
            flag_error($sformatf("last_of_run %0b, expected %0b", last_of_run, want.last));
          if (status !== want.st)
            flag_error($sformatf("status %0d, expected %0d", status, want.st));
        end
      end
    end
  end

  // Output side: random stall bursts, none in the tail.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (!steady_tail && !rst && $urandom_range(0, 7) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic stim_row_t make_row(input kind_t k, input logic [LEN_W-1:0] len,
                                         input logic [31:0] ct, input logic [7:0] db,
                                         input logic [3:0] n, input logic [63:0] bytes,
                                         input status_t st);
    stim_row_t r;
    r.kind         = k;
    r.len          = len;
    r.ctype        = ct;
    r.dbyte        = db;
    r.n_fixed      = n;
    r.fixed_bytes  = bytes;
    r.fixed_status = st;
    return r;
  endfunction

  // A transaction of the given kind with random length, type and data byte, and no typed-in expectation.
  function automatic stim_row_t free_row(input kind_t k);
    stim_row_t r;
    r = '0;
    r.kind         = k;
    r.len          = LEN_W'($urandom());
    r.ctype        = $urandom();
    r.dbyte        = BYTE_W'($urandom_range(0, 255));
    r.fixed_status = STATUS_OK;
    return r;
  endfunction

  // Presents one transaction from a falling edge and holds it until accepted.
  task automatic send_item(input stim_row_t it);
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    cur_item = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds off until every expected byte has been delivered.
  task automatic wait_drain();
    in_valid = 1'b0;
    while (awaited_bytes.size() != 0) @(negedge clk);
  endtask

  // Main stimulus.
  initial begin
    stim_row_t r;
    int        n;
    int        n_data;
    int        base;

    rst          = 1'b1;
    in_valid     = 1'b0;
    cur_item     = '0;
    crc_reg      = CRC_INIT;
    chunk_open   = 1'b0;
    declared_len = '0;
    byte_count   = '0;

    // Directed table; typed-in bytes where they are obvious, model otherwise.
    dir_table[0]  = make_row(KIND_DATA, '1, '1, 8'hFF, 4'd1, '0, STATUS_ORDER);
    dir_table[1]  = make_row(KIND_END, '0, '0, 8'h00, 4'd1, '0, STATUS_ORDER);
    dir_table[2]  = make_row(KIND_SIG, '1, '1, 8'hFF, 4'd8, PNG_MAGIC, STATUS_OK);
    dir_table[3]  = make_row(KIND_START, '0, TYPE_IEND, 8'h00, 4'd8,
                             {32'h0, TYPE_IEND}, STATUS_OK);
    dir_table[4]  = make_row(KIND_SIG, '0, '0, 8'h00, 4'd1, '0, STATUS_ORDER);
    dir_table[5]  = make_row(KIND_START, 31'd5, TYPE_IDAT, 8'h00, 4'd1, '0, STATUS_ORDER);
    dir_table[6]  = make_row(KIND_END, '1, '1, 8'hFF, 4'd4, {IEND_CRC, 32'h0}, STATUS_OK);
    dir_table[7]  = make_row(KIND_START, '1, '1, 8'hFF, 4'd8,
                             {32'h7FFF_FFFF, 32'hFFFF_FFFF}, STATUS_OK);
    dir_table[8]  = make_row(KIND_DATA, '0, '0, 8'h00, 4'd0, '0, STATUS_OK);
    dir_table[9]  = make_row(KIND_DATA, '1, '1, 8'hFF, 4'd0, '0, STATUS_OK);
    dir_table[10] = make_row(KIND_END, '0, '0, 8'h00, 4'd0, '0, STATUS_OK);
    dir_table[11] = make_row(KIND_START, 31'd2, '0, 8'hFF, 4'd8, 64'h0000_0002_0000_0000,
                             STATUS_OK);
    dir_table[12] = make_row(KIND_DATA, 31'd7, '1, 8'hA5, 4'd0, '0, STATUS_OK);
    dir_table[13] = make_row(KIND_DATA, '0, '0, 8'h5A, 4'd0, '0, STATUS_OK);
    dir_table[14] = make_row(KIND_END, '1, '1, 8'h33, 4'd0, '0, STATUS_OK);
    dir_table[15] = make_row(KIND_START, 31'd1, TYPE_IDAT, 8'h00, 4'd8,
                             {32'h1, TYPE_IDAT}, STATUS_OK);
    // Fewer payload bytes than declared.
    dir_table[16] = make_row(KIND_END, '0, '0, 8'h00, 4'd0, '0, STATUS_OK);
    dir_table[17] = make_row(KIND_START, '0, TYPE_TEXT, 8'h00, 4'd8,
                             {32'h0, TYPE_TEXT}, STATUS_OK);
    dir_table[18] = make_row(KIND_DATA, '0, '0, 8'h80, 4'd0, '0, STATUS_OK);
    // More payload bytes than declared.
    dir_table[19] = make_row(KIND_END, '0, '0, 8'h00, 4'd0, '0, STATUS_OK);
    dir_table[20] = make_row(KIND_DATA, '1, '1, 8'h01, 4'd1, '0, STATUS_ORDER);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_table[i]);

    // Let the block drain completely before the random part.
    wait_drain();

    // Random part: mostly well-formed chunks, some signatures and noise.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base >= RANDOM_ITEMS - TAIL_ITEMS) steady_tail = 1'b1;
      case ($urandom_range(0, 9))
        0: send_item(free_row(KIND_SIG));
        1, 2: begin
          for (int j = $urandom_range(1, 3); j > 0; j--) begin
            send_item(free_row(kind_t'($urandom_range(0, 3))));
          end
        end
        default: begin
          n = $urandom_range(0, 10);
          r = free_row(KIND_START);
          if ($urandom_range(0, 7) != 0) r.len = LEN_W'(n);
          send_item(r);
          // Now and then break the declared count by one byte either way.
          n_data = n;
          case ($urandom_range(0, 9))
            0: n_data = n + 1;
            1: if (n > 0) n_data = n - 1;
            default: ;
          endcase
          for (int j = 0; j < n_data; j++) begin
            if ($urandom_range(0, 24) == 0) begin
              send_item(free_row($urandom_range(0, 1) ? KIND_SIG : KIND_START));
            end
            send_item(free_row(KIND_DATA));
          end
          send_item(free_row(KIND_END));
        end
      endcase
      if (!steady_tail && $urandom_range(0, 15) == 0) wait_drain();
    end

    // Closing: drain, allow trailing bytes to show up, then report.
    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (awaited_bytes.size() != 0) begin
      flag_error($sformatf("%0d bytes never delivered", awaited_bytes.size()));
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcw_pkg.sv
rtl/pcw_front.sv
rtl/pcw_queue.sv
rtl/pcw_back.sv
rtl/png_chunk_writer.sv
test/tb_top.sv
